// ===== sv/first_fit_boundary_tag_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the boundary-tag allocator
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold in every cycle.
`define FFBTA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ffbta: assertion failed");
// Consequent that must hold in the cycle after the antecedent.
`define FFBTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffbta: assertion failed");
`else
`define FFBTA_ASSERT(lbl, prop)
`define FFBTA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/ffbta_pkg.sv =====
// ----------------------------------------------------------------------------
// ffbta_pkg
// Shared constants, sequencer codes and link structs of the allocator.
// ----------------------------------------------------------------------------
package ffbta_pkg;

  // Heap layout constants.
  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam int unsigned WORD_BYTES     = 8;
  localparam int unsigned ALIGN_BYTES    = 16;
  localparam int unsigned SPLIT_MIN      = 3 * WORD_BYTES;
  localparam int unsigned FIRST_BLOCK    = 16;
  localparam int unsigned INIT_BREAK     = 32;
  localparam logic [15:0] CHUNK_RESET    = 16'd4096;
  localparam int unsigned FIELD_W        = 16;

  // Input command kinds.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT,
    OP_INIT_W0, OP_INIT_W1, OP_INIT_W2, OP_INIT_W3,
    OP_WALK_RD, OP_STEP,
    OP_GROW_SET, OP_GROW_W0, OP_GROW_W1, OP_GROW_W2,
    OP_M_RD_H, OP_M_RD_P, OP_M_RD_N, OP_M_SUM, OP_M_W0, OP_M_W1,
    OP_PL_RD, OP_PL_EV, OP_PL_W0, OP_PL_W1, OP_PL_W2, OP_PL_W3,
    OP_PL_W0F, OP_PL_W1F,
    OP_FR_W0, OP_FR_W1,
    OP_FAIL, OP_EMIT
  } dp_op_e;

  // Controller states.
  typedef enum logic [5:0] {
    S_INIT0, S_INIT1, S_INIT2, S_INIT3,
    S_IDLE, S_START, S_WALK_RD, S_WALK_EV, S_STEP,
    S_GROW_SET, S_GROW_CHK, S_GROW_W0, S_GROW_W1, S_GROW_W2,
    S_M_RD_H, S_M_RD_P, S_M_RD_N, S_M_SUM, S_M_W0, S_M_W1,
    S_PL_RD, S_PL_EV, S_PL_W0, S_PL_W1, S_PL_W2, S_PL_W3,
    S_PL_W0F, S_PL_W1F,
    S_FR_W0, S_FR_W1,
    S_DONE
  } state_e;

  // Which request the shared sequences are serving.
  typedef enum logic [1:0] {
    MODE_INIT, MODE_ALLOC, MODE_FREE
  } mode_e;

  // Controller to datapath.
  typedef struct packed {
    dp_op_e op;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic p_lt_brk;
    logic rd_zero;
    logic rd_alloc;
    logic fit;
    logic p_eq_addr;
    logic p_first;
    logic grow_ok;
    logic split_ok;
    logic prev_alloc;
    logic req_zero;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== sv/ffbta_datapath.sv =====
// ----------------------------------------------------------------------------
// ffbta_datapath
// Tag memory, heap pointers, block arithmetic and the result register.
// ----------------------------------------------------------------------------
module ffbta_datapath #(
  parameter int unsigned HEAP_BYTES = ffbta_pkg::HEAP_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffbta_pkg::ctrl_cmd_t cmd_i,
  output ffbta_pkg::dp_stat_t  stat_o,
  input  logic [15:0]          in_req_i,
  input  logic [15:0]          in_addr_i,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [15:0]          out_addr_o,
  output logic                 out_status_o
);

  localparam int unsigned ADDR_W = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned TAG_W  = ADDR_W;
  localparam int unsigned CW     = ((ADDR_W > 17) ? ADDR_W : 17) + 1;
  localparam int unsigned WORDS  = HEAP_BYTES / ffbta_pkg::WORD_BYTES;
  localparam int unsigned IDX_W  = $clog2(WORDS);

  localparam logic [CW-1:0] C_FIRST = CW'(ffbta_pkg::FIRST_BLOCK);
  localparam logic [CW-1:0] C_HEAP  = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] C_8     = CW'(ffbta_pkg::WORD_BYTES);
  localparam logic [CW-1:0] C_16    = CW'(ffbta_pkg::ALIGN_BYTES);
  localparam logic [CW-1:0] C_SPLIT = CW'(ffbta_pkg::SPLIT_MIN);
  localparam logic [CW-1:0] C_ROUND = CW'(2 * ffbta_pkg::ALIGN_BYTES - 1);
  localparam logic [TAG_W-1:0] T_PRO = TAG_W'(ffbta_pkg::ALIGN_BYTES + 1);

  // Word index of a byte address.
  function automatic logic [IDX_W-1:0] widx(input logic [CW-1:0] a);
    return a[IDX_W+2:3];
  endfunction

  // Tag memory, one tag per heap word.
  logic [TAG_W-1:0] tag_mem [WORDS];
  logic [TAG_W-1:0] rdata_q;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [TAG_W-1:0] wr_data;

  // Working registers.
  logic [CW-1:0] p_q, p_d, s_q, s_d, a_q, a_d, nb_q, nb_d;
  logic [CW-1:0] brk_q, brk_d, ps_q, ps_d;
  logic          pa_q, pa_d, rz_q, rz_d, stat_q, stat_d;
  logic [15:0]   fa_q, fa_d, res_q, res_d, chunk_q;
  logic          out_valid_q, out_valid_d, out_stat_q, out_stat_d;
  logic [15:0]   out_addr_q, out_addr_d;

  logic [CW-1:0] rd_size, req_sum, ext, grow_bytes, rest;
  logic          rd_alloc;

  assign rd_size  = CW'({rdata_q[TAG_W-1:3], 3'b000});
  assign rd_alloc = rdata_q[0];
  assign req_sum  = CW'(in_req_i) + C_ROUND;
  assign ext      = (a_q > CW'(chunk_q)) ? a_q : CW'(chunk_q);
  assign grow_bytes = {ext[CW-1:3] + (CW-3)'(ext[3]), 3'b000};
  assign rest     = s_q - a_q;

  // Next values and memory port control per operation.
  always_comb begin
    p_d = p_q; s_d = s_q; a_d = a_q; nb_d = nb_q; brk_d = brk_q; ps_d = ps_q;
    pa_d = pa_q; rz_d = rz_q; stat_d = stat_q; fa_d = fa_q; res_d = res_q;
    rd_en = 1'b0; rd_idx = widx(p_q - C_8);
    wr_en = 1'b0; wr_idx = widx(p_q - C_8); wr_data = TAG_W'(s_q);
    out_addr_d = out_addr_q; out_stat_d = out_stat_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (cmd_i.op)
      ffbta_pkg::OP_ACCEPT: begin
        a_d = {req_sum[CW-1:4], 4'b0000};
        rz_d = (in_req_i == '0);
        fa_d = in_addr_i;
        p_d = C_FIRST;
        stat_d = 1'b0;
        res_d = '0;
      end
      ffbta_pkg::OP_INIT_W0: begin
        wr_en = 1'b1; wr_idx = IDX_W'(0); wr_data = '0;
      end
      ffbta_pkg::OP_INIT_W1: begin
        wr_en = 1'b1; wr_idx = IDX_W'(1); wr_data = T_PRO;
      end
      ffbta_pkg::OP_INIT_W2: begin
        wr_en = 1'b1; wr_idx = IDX_W'(2); wr_data = T_PRO;
      end
      ffbta_pkg::OP_INIT_W3: begin
        wr_en = 1'b1; wr_idx = IDX_W'(3); wr_data = TAG_W'(1);
        brk_d = CW'(ffbta_pkg::INIT_BREAK);
        nb_d = CW'(ffbta_pkg::CHUNK_RESET);
      end
      ffbta_pkg::OP_WALK_RD: rd_en = 1'b1;
      ffbta_pkg::OP_STEP: p_d = p_q + rd_size;
      ffbta_pkg::OP_GROW_SET: nb_d = grow_bytes;
      ffbta_pkg::OP_GROW_W0: begin
        wr_en = 1'b1; wr_idx = widx(brk_q - C_8); wr_data = TAG_W'(nb_q);
        p_d = brk_q;
      end
      ffbta_pkg::OP_GROW_W1: begin
        wr_en = 1'b1; wr_idx = widx(p_q + nb_q - C_16); wr_data = TAG_W'(nb_q);
      end
      ffbta_pkg::OP_GROW_W2: begin
        wr_en = 1'b1; wr_idx = widx(p_q + nb_q - C_8); wr_data = TAG_W'(1);
        brk_d = p_q + nb_q;
      end
      ffbta_pkg::OP_M_RD_H: rd_en = 1'b1;
      ffbta_pkg::OP_M_RD_P: begin
        rd_en = 1'b1; rd_idx = widx(p_q - C_16);
        s_d = rd_size;
      end
      ffbta_pkg::OP_M_RD_N: begin
        rd_en = 1'b1; rd_idx = widx(p_q + s_q - C_8);
        pa_d = rd_alloc; ps_d = rd_size;
      end
      ffbta_pkg::OP_M_SUM: begin
        if (pa_q) begin
          s_d = s_q + rd_size;
        end else begin
          p_d = p_q - ps_q;
          s_d = s_q + ps_q + (rd_alloc ? '0 : rd_size);
        end
      end
      ffbta_pkg::OP_M_W0: wr_en = 1'b1;
      ffbta_pkg::OP_M_W1: begin
        wr_en = 1'b1; wr_idx = widx(p_q + s_q - C_16);
      end
      ffbta_pkg::OP_PL_RD: rd_en = 1'b1;
      ffbta_pkg::OP_PL_EV: begin
        s_d = rd_size;
        res_d = p_q[15:0];
      end
      ffbta_pkg::OP_PL_W0: begin
        wr_en = 1'b1; wr_data = TAG_W'(a_q | CW'(1));
      end
      ffbta_pkg::OP_PL_W1: begin
        wr_en = 1'b1; wr_idx = widx(p_q + a_q - C_16); wr_data = TAG_W'(a_q | CW'(1));
      end
      ffbta_pkg::OP_PL_W2: begin
        wr_en = 1'b1; wr_idx = widx(p_q + a_q - C_8); wr_data = TAG_W'(rest);
      end
      ffbta_pkg::OP_PL_W3: begin
        wr_en = 1'b1; wr_idx = widx(p_q + s_q - C_16); wr_data = TAG_W'(rest);
      end
      ffbta_pkg::OP_PL_W0F: begin
        wr_en = 1'b1; wr_data = TAG_W'(s_q | CW'(1));
      end
      ffbta_pkg::OP_PL_W1F: begin
        wr_en = 1'b1; wr_idx = widx(p_q + s_q - C_16); wr_data = TAG_W'(s_q | CW'(1));
      end
      ffbta_pkg::OP_FR_W0: begin
        wr_en = 1'b1; wr_data = TAG_W'(rd_size);
        s_d = rd_size;
      end
      ffbta_pkg::OP_FR_W1: begin
        wr_en = 1'b1; wr_idx = widx(p_q + s_q - C_16);
      end
      ffbta_pkg::OP_FAIL: stat_d = 1'b1;
      ffbta_pkg::OP_EMIT: begin
        out_valid_d = 1'b1;
        out_addr_d = res_q;
        out_stat_d = stat_q;
      end
      default: ;
    endcase
  end

  // Memory ports with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= tag_mem[rd_idx];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      chunk_q     <= ffbta_pkg::CHUNK_RESET;
      brk_q       <= CW'(ffbta_pkg::INIT_BREAK);
    end else begin
      out_valid_q <= out_valid_d;
      brk_q       <= brk_d;
      if (cfg_we_i) begin
        chunk_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    p_q <= p_d; s_q <= s_d; a_q <= a_d; nb_q <= nb_d; ps_q <= ps_d;
    pa_q <= pa_d; rz_q <= rz_d; stat_q <= stat_d; fa_q <= fa_d; res_q <= res_d;
    out_addr_q <= out_addr_d; out_stat_q <= out_stat_d;
  end

  // Status towards the controller.
  always_comb begin
    stat_o.p_lt_brk   = (p_q < brk_q);
    stat_o.rd_zero    = (rd_size == '0);
    stat_o.rd_alloc   = rd_alloc;
    stat_o.fit        = (a_q <= rd_size);
    stat_o.p_eq_addr  = (p_q == CW'(fa_q));
    stat_o.p_first    = (p_q == C_FIRST);
    stat_o.grow_ok    = (nb_q != '0) && (brk_q + nb_q <= C_HEAP);
    stat_o.split_ok   = (rd_size >= a_q + C_SPLIT);
    stat_o.prev_alloc = pa_q;
    stat_o.req_zero   = rz_q;
    stat_o.out_busy   = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_stat_q;

endmodule

// ===== sv/ffbta_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffbta_ctrl
// Sequencer for heap set-up, first-fit walk, growth, merge, place and free.
// ----------------------------------------------------------------------------
module ffbta_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_command_i,
  output logic                 in_ready_o,
  input  ffbta_pkg::dp_stat_t  stat_i,
  output ffbta_pkg::ctrl_cmd_t cmd_o
);

  ffbta_pkg::state_e state_q, state_d;
  ffbta_pkg::mode_e  mode_q, mode_d;
  ffbta_pkg::state_e miss_st, merged_st;
  logic              free_ok;

  // Where the walk goes when the block list ends, and after a merge.
  always_comb begin
    miss_st = (mode_q == ffbta_pkg::MODE_ALLOC) ? ffbta_pkg::S_GROW_SET : ffbta_pkg::S_DONE;
    case (mode_q)
      ffbta_pkg::MODE_ALLOC: merged_st = ffbta_pkg::S_PL_RD;
      ffbta_pkg::MODE_FREE:  merged_st = ffbta_pkg::S_DONE;
      default:               merged_st = ffbta_pkg::S_IDLE;
    endcase
    free_ok = ~stat_i.p_first & stat_i.rd_alloc;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    case (state_q)
      ffbta_pkg::S_INIT0: state_d = ffbta_pkg::S_INIT1;
      ffbta_pkg::S_INIT1: state_d = ffbta_pkg::S_INIT2;
      ffbta_pkg::S_INIT2: state_d = ffbta_pkg::S_INIT3;
      ffbta_pkg::S_INIT3: state_d = ffbta_pkg::S_GROW_CHK;
      ffbta_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ffbta_pkg::S_START;
          mode_d  = (in_command_i == ffbta_pkg::CMD_FREE) ? ffbta_pkg::MODE_FREE
                                                          : ffbta_pkg::MODE_ALLOC;
        end
      end
      ffbta_pkg::S_START: begin
        if (mode_q == ffbta_pkg::MODE_ALLOC && stat_i.req_zero) begin
          state_d = ffbta_pkg::S_DONE;
        end else begin
          state_d = ffbta_pkg::S_WALK_RD;
        end
      end
      ffbta_pkg::S_WALK_RD: state_d = stat_i.p_lt_brk ? ffbta_pkg::S_WALK_EV : miss_st;
      ffbta_pkg::S_WALK_EV: begin
        if (stat_i.rd_zero) begin
          state_d = miss_st;
        end else if (mode_q == ffbta_pkg::MODE_ALLOC) begin
          state_d = (!stat_i.rd_alloc && stat_i.fit) ? ffbta_pkg::S_PL_EV : ffbta_pkg::S_STEP;
        end else if (stat_i.p_eq_addr) begin
          state_d = free_ok ? ffbta_pkg::S_FR_W0 : ffbta_pkg::S_DONE;
        end else begin
          state_d = ffbta_pkg::S_STEP;
        end
      end
      ffbta_pkg::S_STEP:     state_d = ffbta_pkg::S_WALK_RD;
      ffbta_pkg::S_GROW_SET: state_d = ffbta_pkg::S_GROW_CHK;
      ffbta_pkg::S_GROW_CHK: begin
        if (stat_i.grow_ok) begin
          state_d = ffbta_pkg::S_GROW_W0;
        end else if (mode_q == ffbta_pkg::MODE_INIT) begin
          state_d = ffbta_pkg::S_IDLE;
        end else begin
          state_d = ffbta_pkg::S_DONE;
        end
      end
      ffbta_pkg::S_GROW_W0: state_d = ffbta_pkg::S_GROW_W1;
      ffbta_pkg::S_GROW_W1: state_d = ffbta_pkg::S_GROW_W2;
      ffbta_pkg::S_GROW_W2: state_d = ffbta_pkg::S_M_RD_H;
      ffbta_pkg::S_M_RD_H:  state_d = ffbta_pkg::S_M_RD_P;
      ffbta_pkg::S_M_RD_P:  state_d = ffbta_pkg::S_M_RD_N;
      ffbta_pkg::S_M_RD_N:  state_d = ffbta_pkg::S_M_SUM;
      ffbta_pkg::S_M_SUM: begin
        state_d = (stat_i.prev_alloc && stat_i.rd_alloc) ? merged_st : ffbta_pkg::S_M_W0;
      end
      ffbta_pkg::S_M_W0:   state_d = ffbta_pkg::S_M_W1;
      ffbta_pkg::S_M_W1:   state_d = merged_st;
      ffbta_pkg::S_PL_RD:  state_d = ffbta_pkg::S_PL_EV;
      ffbta_pkg::S_PL_EV:  state_d = stat_i.split_ok ? ffbta_pkg::S_PL_W0 : ffbta_pkg::S_PL_W0F;
      ffbta_pkg::S_PL_W0:  state_d = ffbta_pkg::S_PL_W1;
      ffbta_pkg::S_PL_W1:  state_d = ffbta_pkg::S_PL_W2;
      ffbta_pkg::S_PL_W2:  state_d = ffbta_pkg::S_PL_W3;
      ffbta_pkg::S_PL_W3:  state_d = ffbta_pkg::S_DONE;
      ffbta_pkg::S_PL_W0F: state_d = ffbta_pkg::S_PL_W1F;
      ffbta_pkg::S_PL_W1F: state_d = ffbta_pkg::S_DONE;
      ffbta_pkg::S_FR_W0:  state_d = ffbta_pkg::S_FR_W1;
      ffbta_pkg::S_FR_W1:  state_d = ffbta_pkg::S_M_RD_H;
      ffbta_pkg::S_DONE:   state_d = stat_i.out_busy ? ffbta_pkg::S_DONE : ffbta_pkg::S_IDLE;
      default:             state_d = ffbta_pkg::S_IDLE;
    endcase
  end

  // Operation issued in each state.
  always_comb begin
    cmd_o.op   = ffbta_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ffbta_pkg::S_INIT0: cmd_o.op = ffbta_pkg::OP_INIT_W0;
      ffbta_pkg::S_INIT1: cmd_o.op = ffbta_pkg::OP_INIT_W1;
      ffbta_pkg::S_INIT2: cmd_o.op = ffbta_pkg::OP_INIT_W2;
      ffbta_pkg::S_INIT3: cmd_o.op = ffbta_pkg::OP_INIT_W3;
      ffbta_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ffbta_pkg::OP_ACCEPT;
        end
      end
      ffbta_pkg::S_WALK_RD: begin
        if (stat_i.p_lt_brk) begin
          cmd_o.op = ffbta_pkg::OP_WALK_RD;
        end
      end
      ffbta_pkg::S_STEP:     cmd_o.op = ffbta_pkg::OP_STEP;
      ffbta_pkg::S_GROW_SET: cmd_o.op = ffbta_pkg::OP_GROW_SET;
      ffbta_pkg::S_GROW_CHK: begin
        if (!stat_i.grow_ok && mode_q == ffbta_pkg::MODE_ALLOC) begin
          cmd_o.op = ffbta_pkg::OP_FAIL;
        end
      end
      ffbta_pkg::S_GROW_W0: cmd_o.op = ffbta_pkg::OP_GROW_W0;
      ffbta_pkg::S_GROW_W1: cmd_o.op = ffbta_pkg::OP_GROW_W1;
      ffbta_pkg::S_GROW_W2: cmd_o.op = ffbta_pkg::OP_GROW_W2;
      ffbta_pkg::S_M_RD_H:  cmd_o.op = ffbta_pkg::OP_M_RD_H;
      ffbta_pkg::S_M_RD_P:  cmd_o.op = ffbta_pkg::OP_M_RD_P;
      ffbta_pkg::S_M_RD_N:  cmd_o.op = ffbta_pkg::OP_M_RD_N;
      ffbta_pkg::S_M_SUM: begin
        if (!(stat_i.prev_alloc && stat_i.rd_alloc)) begin
          cmd_o.op = ffbta_pkg::OP_M_SUM;
        end
      end
      ffbta_pkg::S_M_W0:   cmd_o.op = ffbta_pkg::OP_M_W0;
      ffbta_pkg::S_M_W1:   cmd_o.op = ffbta_pkg::OP_M_W1;
      ffbta_pkg::S_PL_RD:  cmd_o.op = ffbta_pkg::OP_PL_RD;
      ffbta_pkg::S_PL_EV:  cmd_o.op = ffbta_pkg::OP_PL_EV;
      ffbta_pkg::S_PL_W0:  cmd_o.op = ffbta_pkg::OP_PL_W0;
      ffbta_pkg::S_PL_W1:  cmd_o.op = ffbta_pkg::OP_PL_W1;
      ffbta_pkg::S_PL_W2:  cmd_o.op = ffbta_pkg::OP_PL_W2;
      ffbta_pkg::S_PL_W3:  cmd_o.op = ffbta_pkg::OP_PL_W3;
      ffbta_pkg::S_PL_W0F: cmd_o.op = ffbta_pkg::OP_PL_W0F;
      ffbta_pkg::S_PL_W1F: cmd_o.op = ffbta_pkg::OP_PL_W1F;
      ffbta_pkg::S_FR_W0:  cmd_o.op = ffbta_pkg::OP_FR_W0;
      ffbta_pkg::S_FR_W1:  cmd_o.op = ffbta_pkg::OP_FR_W1;
      ffbta_pkg::S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = ffbta_pkg::OP_EMIT;
        end
      end
      default: ;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffbta_pkg::S_INIT0;
      mode_q  <= ffbta_pkg::MODE_INIT;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

// ===== sv/first_fit_boundary_tag_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_core
// First-fit heap allocator with boundary tags, split, growth and merging.
//
// Channel   Direction  Word
// s_axis    in         tdata = request_bytes, block_address; tuser = command
// m_axis    out        tdata = payload_address; tuser = status
// cfg       in         chunk_bytes write
//
// An allocate walks the block list first-fit and places into the first
// fit; on a miss it grows the heap, merges and places. A free takes the
// same walk to the block, then frees and merges it. The tag memory takes
// at most one tag access a cycle. After reset the heap set-up runs before
// the first word is taken. A result waits in the output register while the
// next request is taken.
// ----------------------------------------------------------------------------
`include "first_fit_boundary_tag_allocator_core_assert.svh"

module first_fit_boundary_tag_allocator_core #(
  parameter int unsigned HEAP_BYTES = ffbta_pkg::HEAP_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [15:0] request_bytes, [31:16] block_address
  input  logic        s_axis_tuser_i,  // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [15:0] payload_address
  output logic        m_axis_tuser_o,  // [0] status
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  ffbta_pkg::ctrl_cmd_t ctrl_cmd;
  ffbta_pkg::dp_stat_t  dp_stat;

  // Sequencer.
  ffbta_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_command_i (s_axis_tuser_i),
    .in_ready_o   (s_axis_tready_o),
    .stat_i       (dp_stat),
    .cmd_o        (ctrl_cmd)
  );

  // Tag memory and arithmetic.
  ffbta_datapath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .in_req_i     (s_axis_tdata_i[15:0]),
    .in_addr_i    (s_axis_tdata_i[31:16]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_addr_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

  // A taken word starts work, so the input closes for the next cycle.
  `FFBTA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // A result appears only when the sequencer emits one.
  `FFBTA_ASSERT(a_emit_source, $rose(m_axis_tvalid_o) |-> $past(ctrl_cmd.op == ffbta_pkg::OP_EMIT))
  // A result is never emitted over one still waiting.
  `FFBTA_ASSERT(a_no_overwrite, ctrl_cmd.op == ffbta_pkg::OP_EMIT |-> !dp_stat.out_busy)

endmodule
